@@ rtl/lvfp_pkg.sv @@
// ----------------------------------------------------------------------------
// lvfp_pkg
// Shared types and constants for the LRU victim unit with mark preference.
// ----------------------------------------------------------------------------
package lvfp_pkg;

    localparam int SETS_DEFAULT = 2048;
    localparam int WAYS_DEFAULT = 16;

    localparam int SET_W      = 11;
    localparam int WAY_W      = 4;
    localparam int ATYPE_W    = 3;
    localparam int MIN_RANK_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic KIND_QUERY  = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    localparam logic [ATYPE_W-1:0] ATYPE_DATA = 3'd0;

    localparam logic [MIN_RANK_W-1:0] MIN_RANK_RESET = 5'd16;

    // word index of each register (paddr[2])
    localparam logic REG_MIN_EVICTION_RANK = 1'b0;

    // request captured at acceptance
    typedef struct packed {
        logic               kind;
        logic [WAY_W-1:0]   way_index;
        logic               hit_flag;
        logic [ATYPE_W-1:0] access_type;
        logic               set_ok;
        logic               way_ok;
    } lvfp_req_t;

    // outcome of one read-modify-write pass
    typedef struct packed {
        logic             wr;
        logic [WAY_W-1:0] victim_way;
        logic             took_alternate;
    } lvfp_pick_t;

endpackage

@@ rtl/lvfp_if.sv @@
// ----------------------------------------------------------------------------
// lvfp_if
// Valid/ready channels for requests and victim results.
// ----------------------------------------------------------------------------
interface lvfp_req_if
    import lvfp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [SET_W-1:0]   set_index;
    logic [WAY_W-1:0]   way_index;
    logic               hit_flag;
    logic [ATYPE_W-1:0] access_type;

    modport source (
        output valid, kind, set_index, way_index, hit_flag, access_type,
        input  ready
    );
    modport sink (
        input  valid, kind, set_index, way_index, hit_flag, access_type,
        output ready
    );
endinterface

interface lvfp_rsp_if
    import lvfp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [WAY_W-1:0] victim_way;
    logic             took_alternate;

    modport source (
        output valid, victim_way, took_alternate,
        input  ready
    );
    modport sink (
        input  valid, victim_way, took_alternate,
        output ready
    );
endinterface

@@ rtl/lru_victim_with_flag_preference_unit.sv @@
// ----------------------------------------------------------------------------
// lru_victim_with_flag_preference_unit
// Per-set LRU victim selection with preference for doubly marked ways.
// ----------------------------------------------------------------------------
// Each set is one RAM word holding rank, hit mark and data mark for every way.
// On a request, the accept cycle in ST_IDLE issues the set read; ST_PROC then
// compares all ways of the returned word in parallel, writes the modified word
// back and loads the result register. A query yields one result, an update
// none. A result waiting in the output register stalls only the following
// query's write-back cycle. After reset, a clearing pass writes the initial
// rank pattern into every set; requests are held off during it, register
// writes are taken. Out-of-range sets answer way 0 and change nothing;
// out-of-range ways are ignored on update.
// ----------------------------------------------------------------------------
module lru_victim_with_flag_preference_unit
    import lvfp_pkg::*;
#(
    parameter int SETS = SETS_DEFAULT,
    parameter int WAYS = WAYS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    lvfp_req_if.sink              req,
    lvfp_rsp_if.source            rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int RW    = $clog2(WAYS);
    localparam int EW    = RW + 2;
    localparam int WORDW = WAYS * EW;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROC
    } state_t;

    state_t                state_reg;
    logic [AW-1:0]         clr_cnt_reg;
    logic [AW-1:0]         addr_reg;
    lvfp_req_t             req_reg;
    logic                  out_valid_reg;
    logic [WAY_W-1:0]      victim_reg;
    logic                  alt_reg;

    logic [MIN_RANK_W-1:0] min_rank;
    logic [16:0]           set_ext;
    logic [AW-1:0]         set_addr;
    logic                  accept;
    logic                  proc_go;
    logic                  load_rsp;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORDW-1:0]      ram_wdata;
    logic [WORDW-1:0]      ram_rdata;
    logic [WORDW-1:0]      rst_word;
    logic [WORDW-1:0]      new_word;
    lvfp_pick_t            pick_res;

    lvfp_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .min_rank (min_rank)
    );

    assign set_ext  = 17'(req.set_index);
    assign set_addr = set_ext[AW-1:0];

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    // a query must find the result register free (or draining)
    assign proc_go = (req_reg.kind == KIND_UPDATE) || !out_valid_reg || rsp.ready;

    assign load_rsp = (state_reg == ST_PROC) && proc_go && (req_reg.kind == KIND_QUERY);

    always_comb
    begin
        for (int k = 0; k < WAYS; k++)
        begin
            rst_word[k*EW +: EW] = EW'(k);
        end
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = rst_word;
        end
        else
        begin
            ram_we    = (state_reg == ST_PROC) && proc_go && pick_res.wr;
            ram_waddr = addr_reg;
            ram_wdata = new_word;
        end
    end

    lvfp_ram #(
        .WIDTH (WORDW),
        .DEPTH (SETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (set_addr),
        .rdata (ram_rdata)
    );

    lvfp_pick #(
        .WAYS (WAYS)
    ) u_pick (
        .word     (ram_rdata),
        .req      (req_reg),
        .min_rank (min_rank),
        .new_word (new_word),
        .res      (pick_res)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg            <= set_addr;
            req_reg.kind        <= req.kind;
            req_reg.way_index   <= req.way_index;
            req_reg.hit_flag    <= req.hit_flag;
            req_reg.access_type <= req.access_type;
            req_reg.set_ok      <= set_ext < 17'(SETS);
            req_reg.way_ok      <= 6'(req.way_index) < 6'(WAYS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            victim_reg    <= '0;
            alt_reg       <= 1'b0;
        end
        else
        begin
            if (load_rsp)
            begin
                out_valid_reg <= 1'b1;
                victim_reg    <= pick_res.victim_way;
                alt_reg       <= pick_res.took_alternate;
            end
            else if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= AW'(clr_cnt_reg + 1'b1);
                    if (clr_cnt_reg == AW'(SETS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_PROC;
                    end
                end
                ST_PROC:
                begin
                    if (proc_go)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.victim_way     = victim_reg;
    assign rsp.took_alternate = alt_reg;

    // the RAM is written only by the clearing pass or a write-back cycle
    a_no_write_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_we
    ) else $error("set RAM written while idle");

    // a new result only comes out of a query's write-back cycle
    a_rsp_from_query: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            $past((state_reg == ST_PROC) && (req_reg.kind == KIND_QUERY))
    ) else $error("result raised without a query");

    // an update never produces a result
    a_update_silent: assert property (
        @(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_PROC) && (req_reg.kind == KIND_UPDATE) && !out_valid_reg)
            |=> !out_valid_reg
    ) else $error("update produced a result");

    // an out-of-range set must not touch the RAM
    a_bad_set_no_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_PROC) && !req_reg.set_ok) |-> !ram_we
    ) else $error("write-back for an out-of-range set");

endmodule

@@ rtl/lvfp_ram.sv @@
// ----------------------------------------------------------------------------
// lvfp_ram
// Generic single-clock RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lvfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/lvfp_cfg.sv @@
// ----------------------------------------------------------------------------
// lvfp_cfg
// APB register slave holding min_eviction_rank.
// ----------------------------------------------------------------------------
module lvfp_cfg
    import lvfp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [MIN_RANK_W-1:0] min_rank
);

    logic [MIN_RANK_W-1:0] min_rank_reg;
    logic                  wr_en;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign min_rank = min_rank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_rank_reg <= MIN_RANK_RESET;
        end
        else if (wr_en && (paddr[2] == REG_MIN_EVICTION_RANK))
        begin
            min_rank_reg <= pwdata[MIN_RANK_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MIN_EVICTION_RANK: prdata = APB_DATA_W'(min_rank_reg);
            default:               prdata = '0;
        endcase
    end

endmodule

@@ rtl/lvfp_pick.sv @@
// ----------------------------------------------------------------------------
// lvfp_pick
// Set-word datapath: victim choice and rank/mark rewrite for one set.
// ----------------------------------------------------------------------------
module lvfp_pick
    import lvfp_pkg::*;
#(
    parameter int WAYS  = WAYS_DEFAULT,
    parameter int RW    = $clog2(WAYS),
    parameter int EW    = RW + 2,
    parameter int WORDW = WAYS * EW
) (
    input  logic [WORDW-1:0]      word,
    input  lvfp_req_t             req,
    input  logic [MIN_RANK_W-1:0] min_rank,
    output logic [WORDW-1:0]      new_word,
    output lvfp_pick_t            res
);

    localparam int NP = 1 << RW;

    logic [NP*EW-1:0] word_pad;
    logic [NP*EW-1:0] new_pad;
    logic [RW-1:0]    t_rank [1:2*NP-1];
    logic [RW-1:0]    t_way  [1:2*NP-1];
    logic [RW-1:0]    lru_way;
    logic [RW-1:0]    alt_way;
    logic [RW-1:0]    alt_rank;
    logic [RW-1:0]    old_rank;
    logic [RW-1:0]    wsel;
    logic [5:0]       way_ext;
    logic [5:0]       sel_ext;
    logic             take_alt;

    assign word_pad = (NP*EW)'(word);
    assign way_ext  = 6'(req.way_index);
    assign wsel     = way_ext[RW-1:0];

    // max rank among doubly marked ways; left child (lower way) wins ties
    always_comb
    begin
        for (int k = 0; k < NP; k++)
        begin
            t_rank[NP+k] = (word_pad[k*EW+RW] && word_pad[k*EW+RW+1])
                           ? word_pad[k*EW +: RW] : '0;
            t_way[NP+k]  = RW'(k);
        end
        for (int k = NP - 1; k >= 1; k--)
        begin
            if (t_rank[2*k+1] > t_rank[2*k])
            begin
                t_rank[k] = t_rank[2*k+1];
                t_way[k]  = t_way[2*k+1];
            end
            else
            begin
                t_rank[k] = t_rank[2*k];
                t_way[k]  = t_way[2*k];
            end
        end
    end

    assign alt_rank = t_rank[1];
    assign alt_way  = t_way[1];
    assign take_alt = 6'(alt_rank) >= 6'(min_rank);

    // highest way sitting at the oldest rank, way 0 if none
    always_comb
    begin
        lru_way  = '0;
        old_rank = '0;
        for (int k = 0; k < WAYS; k++)
        begin
            if (word_pad[k*EW +: RW] == RW'(WAYS - 1))
            begin
                lru_way = RW'(k);
            end
            if (RW'(k) == wsel)
            begin
                old_rank = word_pad[k*EW +: RW];
            end
        end
    end

    always_comb
    begin
        logic [RW-1:0] rk;
        new_pad = word_pad;
        for (int k = 0; k < WAYS; k++)
        begin
            rk = word_pad[k*EW +: RW];
            if (req.kind == KIND_QUERY)
            begin
                if (take_alt && (rk > alt_rank))
                begin
                    new_pad[k*EW +: RW] = RW'(rk - 1'b1);
                end
            end
            else if (RW'(k) == wsel)
            begin
                new_pad[k*EW +: RW]  = '0;
                new_pad[k*EW+RW]     = req.hit_flag;
                new_pad[k*EW+RW+1]   = (req.access_type == ATYPE_DATA);
            end
            else if ((rk <= old_rank) && (rk < RW'(WAYS - 1)))
            begin
                new_pad[k*EW +: RW] = RW'(rk + 1'b1);
            end
        end
    end

    assign new_word = new_pad[WORDW-1:0];

    assign sel_ext = take_alt ? 6'(alt_way) : 6'(lru_way);

    always_comb
    begin
        res.wr             = req.set_ok &&
                             ((req.kind == KIND_UPDATE) ? req.way_ok : take_alt);
        res.victim_way     = req.set_ok ? sel_ext[WAY_W-1:0] : '0;
        res.took_alternate = req.set_ok && take_alt;
    end

endmodule
